[rtl/vaos_pkg.sv]
// ----------------------------------------------------------------------------
// vaos_pkg
// Shared types and constants for the oldest-steal voice allocator.
// ----------------------------------------------------------------------------
package vaos_pkg;

   localparam int NUM_VOICES_DEF = 16;
   localparam int NUM_VOICES_MAX = 64;

   // field widths of the request and result
   localparam int TIME_W  = 48;
   localparam int VSEL_W  = 4;
   localparam int BCNT_W  = 5;
   // voice index carried along the chain, wide enough for the largest build
   localparam int VIDX_W  = $clog2(NUM_VOICES_MAX);

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEAL_EN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VOICES   = CSR_IDX_W'(1);
   localparam logic [CSR_DATA_W-1:0] VOICES_RST  = CSR_DATA_W'(16);

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_REL_ALL = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [VSEL_W-1:0] voice_sel;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [VSEL_W-1:0] voice_index;
      logic              stolen;
      logic [BCNT_W-1:0] busy_count;
   } rsp_type;

   // scan record handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [VIDX_W-1:0] free_idx;
      logic              have;
      logic [VIDX_W-1:0] best_idx;
      logic [TIME_W-1:0] best_time;
   } scan_type;

   // update broadcast to all cells
   typedef struct packed {
      logic              set;
      logic              clr;
      logic              clr_all;
      logic [VIDX_W-1:0] idx;
      logic [TIME_W-1:0] stamp;
   } wr_type;

endpackage

[rtl/vaos_cell.sv]
// ----------------------------------------------------------------------------
// vaos_cell
// One voice: busy flag and start time. Folds its state into the passing
// scan record and registers it for the next cell.
// ----------------------------------------------------------------------------
module vaos_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               active,
   input  vaos_pkg::scan_type scan_in,
   output vaos_pkg::scan_type scan_out,
   input  vaos_pkg::wr_type   wr,
   output logic               busy_out
);
   import vaos_pkg::*;

   localparam logic [VIDX_W-1:0] MY_IDX = VIDX_W'(CELL_IDX);

   logic              busy_ff, busy_in;
   logic [TIME_W-1:0] start_ff, start_in;
   scan_type          scan_ff, scan_in_c;

   always_comb begin
      scan_in_c = scan_in;
      if (active) begin
         if (!scan_in.found && !busy_ff) begin
            scan_in_c.found    = 1'b1;
            scan_in_c.free_idx = MY_IDX;
         end
         // strict less-than keeps the lower index on equal times
         if (!scan_in.have || (start_ff < scan_in.best_time)) begin
            scan_in_c.have      = 1'b1;
            scan_in_c.best_idx  = MY_IDX;
            scan_in_c.best_time = start_ff;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      start_in = start_ff;
      if (wr.clr_all) begin
         busy_in = 1'b0;
      end else if (wr.idx == MY_IDX) begin
         if (wr.set) begin
            busy_in  = 1'b1;
            start_in = wr.stamp;
         end else if (wr.clr) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         scan_ff <= scan_in_c;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   assign scan_out = scan_ff;
   assign busy_out = busy_ff;

endmodule

[rtl/vaos_ctrl.sv]
// ----------------------------------------------------------------------------
// vaos_ctrl
// Request sequencing, configuration registers, busy count and result
// register for the voice allocator.
// ----------------------------------------------------------------------------
module vaos_ctrl #(
   parameter int NUM_VOICES = vaos_pkg::NUM_VOICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  vaos_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output vaos_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vaos_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vaos_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output vaos_pkg::scan_type                  scan_launch,
   input  vaos_pkg::scan_type                  scan_last,
   output vaos_pkg::wr_type                    wr,
   input  logic [NUM_VOICES-1:0]               busy_vec,
   output logic [NUM_VOICES-1:0]               active_vec
);
   import vaos_pkg::*;

   localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CNT_W = $clog2(NUM_VOICES + 1);
   // wide enough to hold NUM_VOICES itself for the range check
   localparam int SEL_W = (CNT_W > VSEL_W) ? CNT_W : VSEL_W;
   localparam int CMP_W = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic                  steal_en_ff, steal_en_in;
   logic [CSR_DATA_W-1:0] voices_ff, voices_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  accept;
   logic [SEL_W-1:0]      sel_w;
   logic                  sel_ok;
   logic [IDX_W-1:0]      sel_idx;
   logic [CMP_W-1:0]      voices_ext;
   logic [CNT_W-1:0]      voices_eff;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign sel_w   = SEL_W'(req_data.voice_sel);
   assign sel_ok  = (sel_w < SEL_W'(NUM_VOICES));
   assign sel_idx = IDX_W'(sel_w);

   // voices in use, saturated to the build size
   assign voices_ext = CMP_W'(voices_ff);
   assign voices_eff = (voices_ext > CMP_W'(NUM_VOICES)) ? CNT_W'(NUM_VOICES)
                                                         : CNT_W'(voices_ext);

   for (genvar gi = 0; gi < NUM_VOICES; gi++) begin : g_active
      assign active_vec[gi] = (CNT_W'(gi) < voices_eff);
   end

   always_comb begin
      steal_en_in = steal_en_ff;
      voices_in   = voices_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEAL_EN: steal_en_in = csr_wdata[0];
            CSR_VOICES:   voices_in   = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr           = '0;
      scan_launch  = '0;
      wr.stamp     = req_ff.now_time;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               rsp_valid_in = 1'b1;
               case (req_data.cmd)
                  CMD_ALLOC: begin
                     scan_launch.valid = 1'b1;
                     rsp_valid_in      = 1'b0;
                     state_in          = ST_SCAN;
                  end
                  CMD_RELEASE: begin
                     if (sel_ok) begin
                        wr.clr = 1'b1;
                        wr.idx = VIDX_W'(sel_idx);
                        if (busy_vec[sel_idx]) begin
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  CMD_REL_ALL: begin
                     wr.clr_all = 1'b1;
                     count_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // scan front has crossed the last cell
            if (scan_last.valid) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (scan_last.found) begin
                  wr.set              = 1'b1;
                  wr.idx              = scan_last.free_idx;
                  count_in            = count_ff + CNT_W'(1);
                  rsp_in.granted      = 1'b1;
                  rsp_in.voice_index  = VSEL_W'(scan_last.free_idx);
               end else if (scan_last.have && steal_en_ff) begin
                  wr.set              = 1'b1;
                  wr.idx              = scan_last.best_idx;
                  rsp_in.granted      = 1'b1;
                  rsp_in.stolen       = 1'b1;
                  rsp_in.voice_index  = VSEL_W'(scan_last.best_idx);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_in.busy_count = BCNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         steal_en_ff  <= 1'b1;
         voices_ff    <= VOICES_RST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steal_en_ff  <= steal_en_in;
         voices_ff    <= voices_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/voice_allocator_oldest_steal_top.sv]
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_top
// Polyphonic voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Each voice lives in a cell of a chain. An allocate request sends a scan
// record down the chain, one cell per cycle, picking up the lowest free voice
// and the oldest start time; the result strobe follows once the record has
// left the last cell and passed the result register. Release, release all
// and query do not scan: the result strobe follows in the next cycle and a
// new request may be accepted in that same cycle. busy is high
// only while a scan runs. rsp_valid is high for exactly one cycle per request
// and the result cannot be held off, so the receiver must take it then.
// Configuration writes are always ready and should be issued only while idle.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_top #(
   parameter int NUM_VOICES = vaos_pkg::NUM_VOICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  vaos_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output vaos_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vaos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vaos_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vaos_pkg::*;

   scan_type              chain [NUM_VOICES+1];
   wr_type                wr;
   logic [NUM_VOICES-1:0] busy_vec;
   logic [NUM_VOICES-1:0] active_vec;

   vaos_ctrl #(
      .NUM_VOICES (NUM_VOICES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .scan_launch (chain[0]),
      .scan_last   (chain[NUM_VOICES]),
      .wr          (wr),
      .busy_vec    (busy_vec),
      .active_vec  (active_vec)
   );

   for (genvar gi = 0; gi < NUM_VOICES; gi++) begin : g_cell
      vaos_cell #(
         .CELL_IDX (gi)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .active   (active_vec[gi]),
         .scan_in  (chain[gi]),
         .scan_out (chain[gi+1]),
         .wr       (wr),
         .busy_out (busy_vec[gi])
      );
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oldest-steal voice allocator. A directed run
// fills every voice, steals ties and the oldest stamp and frees voices; then
// random note streams run under changing register settings and sender
// idling. Every result is checked against an in-bench model of the voices.
// ----------------------------------------------------------------------------
module tb_top;
   import vaos_pkg::*;

   localparam int NV        = NUM_VOICES_DEF;
   localparam int STALL_MAX = 4000;

   typedef enum logic [1:0] {
      STEP_REQ,
      STEP_CSR,
      STEP_PAUSE
   } step_kind;

   typedef struct {
      step_kind                kind;
      req_type                 req;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   wdata;
      int unsigned             idle_pct;
   } note_step;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   note_step    note_events[$];
   rsp_type     owed_grants[$];
   int unsigned sender_idle = 14;
   int          mismatches  = 0;
   int          stall_cycles = 0;

   // voice model
   logic              steal_on   = 1'b1;
   logic [4:0]        voices_cfg = 5'd16;
   logic              voice_on    [NV];
   logic [TIME_W-1:0] voice_stamp [NV];

   initial begin
      foreach (voice_on[i]) begin
         voice_on[i]    = 1'b0;
         voice_stamp[i] = '0;
      end
   end

   voice_allocator_oldest_steal_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic rsp_type allocate_step(req_type r);
      rsp_type res;
      int      n;
      int      best;
      int      cnt;
      bit      found;
      res   = '0;
      found = 1'b0;
      case (r.cmd)
         CMD_ALLOC: begin
            n = (voices_cfg > NV) ? NV : voices_cfg;
            for (int i = 0; i < n && !found; i++) begin
               if (!voice_on[i]) begin
                  found          = 1'b1;
                  voice_on[i]    = 1'b1;
                  voice_stamp[i] = r.now_time;
                  res.granted    = 1'b1;
                  res.voice_index = VSEL_W'(i);
               end
            end
            // every voice in use is busy: take the oldest, lowest index on ties
            if (!found && n > 0 && steal_on) begin
               best = 0;
               for (int i = 1; i < n; i++)
                  if (voice_stamp[i] < voice_stamp[best]) best = i;
               voice_stamp[best] = r.now_time;
               voice_on[best]    = 1'b1;
               res.granted       = 1'b1;
               res.stolen        = 1'b1;
               res.voice_index   = VSEL_W'(best);
            end
         end
         CMD_RELEASE: voice_on[r.voice_sel] = 1'b0;
         CMD_REL_ALL: foreach (voice_on[i]) voice_on[i] = 1'b0;
         default: ;
      endcase
      cnt = 0;
      foreach (voice_on[i]) if (voice_on[i]) cnt++;
      res.busy_count = BCNT_W'(cnt);
      return res;
   endfunction

   task automatic queue_req(cmd_type c, int sel, logic [TIME_W-1:0] t);
      note_step s;
      s.kind          = STEP_REQ;
      s.req.cmd       = c;
      s.req.voice_sel = VSEL_W'(sel);
      s.req.now_time  = t;
      s.idx           = '0;
      s.wdata         = '0;
      s.idle_pct      = sender_idle;
      note_events.push_back(s);
   endtask

   task automatic queue_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] wdata);
      note_step s;
      s.kind     = STEP_CSR;
      s.req      = '0;
      s.idx      = idx;
      s.wdata    = wdata;
      s.idle_pct = 0;
      note_events.push_back(s);
   endtask

   task automatic queue_pause();
      note_step s;
      s.kind     = STEP_PAUSE;
      s.req      = '0;
      s.idx      = '0;
      s.wdata    = '0;
      s.idle_pct = 0;
      note_events.push_back(s);
   endtask

   // driver: retires what the block took at this edge, then offers the next step
   always @(posedge clock) begin : drive
      bit took;
      bit quiet;
      bit nx_start;
      bit nx_csr;
      if (!reset) begin
         took = 1'b0;
         if (start && !busy) begin
            owed_grants.push_back(allocate_step(req_data));
            took = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_STEAL_EN)
               steal_on = csr_wdata[0];
            else if (csr_index == CSR_VOICES)
               voices_cfg = csr_wdata;
            took = 1'b1;
         end
         if (took || !(start || csr_valid)) begin
            nx_start = 1'b0;
            nx_csr   = 1'b0;
            // rsp_valid guard keeps this independent of the monitor's pop order
            quiet = owed_grants.size() == 0 && !rsp_valid;
            if (note_events.size() != 0) begin
               case (note_events[0].kind)
                  STEP_REQ: begin
                     if ($urandom_range(99) >= note_events[0].idle_pct) begin
                        req_data <= note_events[0].req;
                        nx_start = 1'b1;
                        void'(note_events.pop_front());
                     end
                  end
                  STEP_CSR: begin
                     if (quiet) begin
                        csr_index <= note_events[0].idx;
                        csr_wdata <= note_events[0].wdata;
                        nx_csr = 1'b1;
                        void'(note_events.pop_front());
                     end
                  end
                  default: begin
                     if (quiet) void'(note_events.pop_front());
                  end
               endcase
            end
            start     <= nx_start;
            csr_valid <= nx_csr;
         end
      end
   end

   always @(posedge clock) begin : check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result g=%0d v=%0d s=%0d cnt=%0d",
                        rsp_data.granted, rsp_data.voice_index, rsp_data.stolen,
                        rsp_data.busy_count);
         end else begin
            want = owed_grants.pop_front();
            if (rsp_data.granted !== want.granted ||
                rsp_data.voice_index !== want.voice_index ||
                rsp_data.stolen !== want.stolen ||
                rsp_data.busy_count !== want.busy_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: exp g=%0d v=%0d s=%0d cnt=%0d got g=%0d v=%0d s=%0d cnt=%0d",
                           want.granted, want.voice_index, want.stolen, want.busy_count,
                           rsp_data.granted, rsp_data.voice_index, rsp_data.stolen,
                           rsp_data.busy_count);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : stimulus
      logic              en;
      logic [4:0]        nv;
      int                tmode;
      int                span;
      int                pick;
      logic [TIME_W-1:0] stamp;

      // directed: empty state, fill all voices, steal ties, free and refill
      queue_req(CMD_QUERY, 0, '0);
      queue_req(CMD_RELEASE, 5, '0);
      for (int i = 0; i < NV; i++)
         queue_req(CMD_ALLOC, 15 - i, (i == 0) ? '1 :
                   (i <= 2) ? '0 : TIME_W'(i * 1000));
      queue_req(CMD_ALLOC, 0, TIME_W'(5));
      queue_req(CMD_ALLOC, 0, TIME_W'(5));
      queue_req(CMD_RELEASE, 15, '1);
      queue_req(CMD_ALLOC, 0, TIME_W'(7));
      queue_req(CMD_REL_ALL, 0, '0);
      queue_req(CMD_QUERY, 15, '1);
      queue_csr(CSR_VOICES, 5'd0);
      queue_req(CMD_ALLOC, 0, TIME_W'(9));

      // random note streams, one register setting per segment
      stamp = TIME_W'({$urandom, $urandom});
      for (int seg = 0; seg < 12; seg++) begin
         sender_idle = (seg < 4) ? 14 : (seg < 8) ? 87 : 0;
         case (seg)
            0: begin en = 1'b0; nv = 5'd31; end
            1: begin en = 1'b1; nv = 5'd1;  end
            2: begin en = 1'b1; nv = 5'd0;  end
            3: begin en = 1'b1; nv = 5'd16; end
            default: begin
               en   = 1'($urandom_range(3) != 0);
               pick = $urandom_range(99);
               nv   = (pick < 60) ? 5'($urandom_range(1, 16)) :
                      (pick < 80) ? 5'($urandom_range(2, 4)) :
                      (pick < 95) ? 5'($urandom_range(17, 31)) : 5'd0;
            end
         endcase
         queue_csr(CSR_STEAL_EN, CSR_DATA_W'(en));
         queue_csr(CSR_VOICES, nv);
         span  = (nv == 0) ? 1 : (nv > NV) ? NV : nv;
         tmode = $urandom_range(2);
         for (int k = 0; k < 146; k++) begin
            // hold off until the block has answered everything
            if (k == 70 && seg % 4 == 1) queue_pause();
            case (tmode)
               0: stamp = TIME_W'({$urandom, $urandom});
               1: stamp = stamp + TIME_W'($urandom_range(1, 500));
               default: stamp = TIME_W'($urandom_range(7));
            endcase
            pick = $urandom_range(99);
            if (pick < 50)
               queue_req(CMD_ALLOC, $urandom_range(15), stamp);
            else if (pick < 80)
               queue_req(CMD_RELEASE,
                         $urandom_range(1) ? $urandom_range(15) : $urandom_range(span - 1),
                         stamp);
            else if (pick < 84)
               queue_req(CMD_REL_ALL, $urandom_range(15), stamp);
            else
               queue_req(CMD_QUERY, $urandom_range(15), stamp);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (note_events.size() != 0 || start || csr_valid || owed_grants.size() != 0)
         @(negedge clock);
      repeat (NV + 4) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
